@@ rtl/rwm_pkg.sv @@
// Shared constants, codes and transaction types for the region write monitor.
package rwm_pkg;

    localparam int NUM_REGIONS_D      = 8;
    localparam int PAGES_PER_REGION_D = 256;
    localparam int PAGE_SIZE_D        = 4096;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_MODE  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_ALL   = 2'd2;

    localparam logic [4:0] UNTYPED = 5'd31;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  slot;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [4:0]  region_type;
        logic [1:0]  mode;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic       address_valid;
        logic       region_hit;
        logic [2:0] hit_slot;
        logic [4:0] hit_type;
        logic [7:0] page_index;
        logic       first_write;
        logic       notify;
        logic       page_overflow;
        logic [8:0] dirty_count;
    } t_rsp;

endpackage

@@ rtl/rwm_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface rwm_req_if;
    logic         valid;
    logic         ready;
    rwm_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rwm_rsp_if;
    logic         valid;
    logic         ready;
    rwm_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rwm_dirty_mem.sv @@
// Single-port dirty page bitmap with registered read.
module rwm_dirty_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rwm_match.sv @@
// Shared region compare unit: aligned span, exact bounds and page number.
module rwm_match #(
    parameter int PAGE_SIZE = 4096
) (
    input  logic [31:0]                     i_start,
    input  logic [31:0]                     i_end,
    input  logic [31:0]                     i_addr,
    output logic                            o_span,
    output logic                            o_exact,
    output logic [31-$clog2(PAGE_SIZE):0]   o_page
);

    localparam int          PS_SH = $clog2(PAGE_SIZE);
    localparam logic [32:0] MASK  = 33'(PAGE_SIZE - 1);

    logic [31:0] lo;
    logic [32:0] hi;
    logic [31:0] diff;

    always_comb begin
        lo      = i_start & ~MASK[31:0];
        hi      = ({1'b0, i_end} + MASK) & ~MASK;
        o_span  = (i_addr >= lo) && ({1'b0, i_addr} <= hi);
        o_exact = (i_addr >= i_start) && (i_addr <= i_end);
        diff    = i_addr - lo;
        o_page  = diff[31:PS_SH];
    end

endmodule

@@ rtl/region_write_monitor.sv @@
// Region write monitor: a table of address regions searched one slot per cycle by
// a shared compare unit, with a per-slot dirty page bitmap in a single-port memory.
// A load clears the slot's bitmap, PAGES_PER_REGION bits, before it responds. A
// write that matches the last-hit region goes through check, bitmap read, bitmap
// write and response. Any other write scans every slot, one per cycle; a hit then
// goes on to bitmap read, bitmap write and response, and a miss responds straight
// after the scan. When a last-hit region was checked first and did not match, the
// scan follows that check. After reset the block clears the whole bitmap,
// NUM_REGIONS * PAGES_PER_REGION bits, before it accepts its first transaction.
module region_write_monitor #(
    parameter int NUM_REGIONS      = rwm_pkg::NUM_REGIONS_D,
    parameter int PAGES_PER_REGION = rwm_pkg::PAGES_PER_REGION_D,
    parameter int PAGE_SIZE        = rwm_pkg::PAGE_SIZE_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwm_req_if.sink    i_req,
    rwm_rsp_if.source  o_rsp
);

    localparam int SLOT_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int RK_W   = $clog2(NUM_REGIONS + 1);
    localparam int PS_SH  = $clog2(PAGE_SIZE);
    localparam int PGF_W  = 32 - PS_SH;
    localparam int PG_W   = (PAGES_PER_REGION > 1) ? $clog2(PAGES_PER_REGION) : 1;
    localparam int DT_W   = $clog2(PAGES_PER_REGION + 1);
    localparam int BITS   = NUM_REGIONS * PAGES_PER_REGION;
    localparam int MA_W   = (BITS > 1) ? $clog2(BITS) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CLR  = 7'b0000010,
        S_LAST = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_RD   = 7'b0010000,
        S_WR   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state            r_state;
    logic [31:0]       r_start [NUM_REGIONS];
    logic [31:0]       r_end   [NUM_REGIONS];
    logic [4:0]        r_kind  [NUM_REGIONS];
    logic [1:0]        r_mode  [NUM_REGIONS];
    logic [RK_W-1:0]   r_rank  [NUM_REGIONS];
    logic [DT_W-1:0]   r_total [NUM_REGIONS];
    logic [RK_W-1:0]   r_rank_cnt;
    logic [SLOT_W-1:0] r_last;
    logic              r_last_vld;
    logic [31:0]       r_addr;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_hit;
    logic              r_found;
    logic              r_valid;
    logic [RK_W-1:0]   r_best;
    logic [PGF_W-1:0]  r_page;
    logic              r_over;
    logic [MA_W-1:0]   r_clr_addr;
    logic [MA_W-1:0]   r_clr_end;
    logic              r_clr_rsp;
    rwm_pkg::t_rsp     r_rsp;

    rwm_pkg::t_req     req;
    logic [SLOT_W-1:0] s;
    logic              slot_ok;
    logic [1:0]        mode_in;
    logic [RK_W-1:0]   r0;
    logic [RK_W-1:0]   lv_rank [NUM_REGIONS];
    logic [RK_W-1:0]   mk_rank [NUM_REGIONS];
    logic [RK_W-1:0]   lv_cnt;
    logic [SLOT_W-1:0] u_sel;
    logic              u_span;
    logic              u_exact;
    logic [PGF_W-1:0]  u_page;
    logic              u_over;
    logic              scan_in;
    logic              scan_take;
    logic              scan_found;
    logic [SLOT_W-1:0] scan_hit;
    logic [MA_W-1:0]   base;
    logic [MA_W-1:0]   mem_addr;
    logic              mem_we;
    logic              mem_wdata;
    logic              mem_rdata;
    logic              mark_ok;
    logic              first;
    logic [DT_W-1:0]   total_new;
    rwm_pkg::t_rsp     blank;

    assign req     = i_req.data;
    assign s       = SLOT_W'(req.slot);
    assign slot_ok = 32'(req.slot) < NUM_REGIONS;
    assign mode_in = (req.mode == 2'd3) ? rwm_pkg::MODE_NONE : req.mode;

    // leaving the search order: higher ranks close the gap
    always_comb begin
        r0 = r_rank[s];
        for (int i = 0; i < NUM_REGIONS; i++) begin
            if (r0 != '0 && r_rank[i] > r0) begin
                lv_rank[i] = r_rank[i] - 1'b1;
            end else begin
                lv_rank[i] = r_rank[i];
            end
        end
        lv_rank[s] = '0;
        lv_cnt     = r_rank_cnt - RK_W'(r0 != '0);
        // same, then rejoin as the newest entry
        for (int i = 0; i < NUM_REGIONS; i++) begin
            mk_rank[i] = lv_rank[i];
        end
        mk_rank[s] = lv_cnt + 1'b1;
    end

    always_comb begin
        case (r_state)
            S_LAST:  u_sel = r_last;
            S_SCAN:  u_sel = r_idx;
            default: u_sel = r_hit;
        endcase
    end

    rwm_match #(.PAGE_SIZE(PAGE_SIZE)) u_match (
        .i_start (r_start[u_sel]),
        .i_end   (r_end[u_sel]),
        .i_addr  (r_addr),
        .o_span  (u_span),
        .o_exact (u_exact),
        .o_page  (u_page)
    );

    assign u_over = 32'(u_page) >= PAGES_PER_REGION;

    always_comb begin
        scan_in    = (r_rank[r_idx] != '0) && u_span;
        scan_take  = scan_in && u_exact && (r_rank[r_idx] > r_best);
        scan_found = r_found || scan_take;
        scan_hit   = scan_take ? r_idx : r_hit;
    end

    assign base = MA_W'(32'(r_hit) * PAGES_PER_REGION);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        case (r_state)
            S_CLR: begin
                mem_addr = r_clr_addr;
                mem_we   = 1'b1;
            end
            S_RD:    mem_addr = base + MA_W'(u_page[PG_W-1:0]);
            S_WR: begin
                mem_addr  = base + MA_W'(r_page[PG_W-1:0]);
                mem_we    = first;
                mem_wdata = 1'b1;
            end
            default: mem_addr = r_clr_addr;
        endcase
    end

    rwm_dirty_mem #(.DEPTH(BITS), .AW(MA_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mark_ok   = (r_kind[r_hit] != rwm_pkg::UNTYPED) &&
                    (r_mode[r_hit] == rwm_pkg::MODE_FIRST ||
                     r_mode[r_hit] == rwm_pkg::MODE_ALL);
        first     = (r_state == S_WR) && mark_ok && !r_over && !mem_rdata;
        total_new = r_total[r_hit] + DT_W'(first);
        blank     = '0;
        blank.hit_type = rwm_pkg::UNTYPED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_end  <= MA_W'(BITS - 1);
            r_clr_rsp  <= 1'b0;
            r_rank_cnt <= '0;
            r_last     <= '0;
            r_last_vld <= 1'b0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
                r_kind[i]  <= rwm_pkg::UNTYPED;
                r_mode[i]  <= rwm_pkg::MODE_NONE;
                r_rank[i]  <= '0;
                r_total[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_addr  <= req.address;
                        r_rsp   <= blank;
                        r_state <= S_OUT;
                        if (req.opcode == rwm_pkg::OP_LOAD && slot_ok) begin
                            r_start[s] <= req.start_addr;
                            r_end[s]   <= req.end_addr;
                            r_kind[s]  <= req.region_type;
                            r_mode[s]  <= rwm_pkg::MODE_NONE;
                            r_total[s] <= '0;
                            r_rank     <= lv_rank;
                            r_rank_cnt <= lv_cnt;
                            if (r_last_vld && r_last == s) begin
                                r_last_vld <= 1'b0;
                            end
                            r_clr_addr <= MA_W'(32'(s) * PAGES_PER_REGION);
                            r_clr_end  <= MA_W'(32'(s) * PAGES_PER_REGION
                                                + PAGES_PER_REGION - 1);
                            r_clr_rsp  <= 1'b1;
                            r_state    <= S_CLR;
                        end else if (req.opcode == rwm_pkg::OP_MODE && slot_ok) begin
                            r_mode[s] <= mode_in;
                            if (mode_in != rwm_pkg::MODE_NONE) begin
                                r_rank     <= mk_rank;
                                r_rank_cnt <= lv_cnt + 1'b1;
                            end
                        end else if (req.opcode == rwm_pkg::OP_WRITE) begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_valid <= 1'b0;
                            r_best  <= '0;
                            r_state <= r_last_vld ? S_LAST : S_SCAN;
                        end
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == r_clr_end) begin
                        r_state <= r_clr_rsp ? S_OUT : S_IDLE;
                    end
                end
                S_LAST: begin
                    if (u_span) begin
                        r_valid <= 1'b1;
                    end
                    if (u_span && u_exact) begin
                        r_found <= 1'b1;
                        r_hit   <= r_last;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_in) begin
                        r_valid <= 1'b1;
                    end
                    if (scan_take) begin
                        r_best <= r_rank[r_idx];
                    end
                    r_found <= scan_found;
                    r_hit   <= scan_hit;
                    r_idx   <= r_idx + 1'b1;
                    if (r_idx == SLOT_W'(NUM_REGIONS - 1)) begin
                        if (scan_found) begin
                            r_last     <= scan_hit;
                            r_last_vld <= 1'b1;
                            r_state    <= S_RD;
                        end else begin
                            r_rsp.address_valid <= r_valid || scan_in;
                            r_state             <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_page  <= u_page;
                    r_over  <= u_over;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_total[r_hit]      <= total_new;
                    r_rsp.address_valid <= r_valid;
                    r_rsp.region_hit    <= 1'b1;
                    r_rsp.hit_slot      <= 3'(r_hit);
                    r_rsp.hit_type      <= r_kind[r_hit];
                    r_rsp.page_index    <= (32'(r_page) > 255) ? 8'd255 : 8'(r_page);
                    r_rsp.first_write   <= first;
                    r_rsp.notify        <= mark_ok &&
                                           (r_mode[r_hit] == rwm_pkg::MODE_ALL || first);
                    r_rsp.page_overflow <= r_over;
                    r_rsp.dirty_count   <= (32'(total_new) > 511) ? 9'd511
                                                                  : 9'(total_new);
                    r_state             <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_clr_rsp <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = r_rsp;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rank_cnt) <= NUM_REGIONS)
        else $error("search order longer than the table");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && r_rsp.region_hit |-> r_rsp.address_valid)
        else $error("region hit without a valid address");

    a_miss_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !r_rsp.region_hit |->
            r_rsp.dirty_count == '0 && r_rsp.hit_type == rwm_pkg::UNTYPED)
        else $error("miss response carries hit fields");

    a_first_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR && first |=> r_state == S_OUT && r_rsp.notify)
        else $error("first write without notification");

endmodule

@@ test/region_write_monitor_tb.sv @@
// Testbench for the region write monitor: directed table, then random transactions.
module region_write_monitor_tb;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rwm_req_if req_ch ();
    rwm_rsp_if rsp_ch ();

    region_write_monitor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [31:0] pr_start [8];
    logic [31:0] pr_end [8];
    logic [4:0]  pr_kind [8];
    logic [1:0]  pr_mode [8];
    int          pr_rank [8];
    int          pr_rank_cnt;
    bit          pr_dirty [8][256];
    int          pr_total [8];
    int          pr_last;
    bit          pr_last_ok;

    rwm_pkg::t_rsp rsp_queue [$];
    int   err_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   recv_hold = 1'b0;

    typedef struct {
        rwm_pkg::t_req req;
        bit            has_exp;
        rwm_pkg::t_rsp exp;
    } t_row;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    function automatic rwm_pkg::t_rsp idle_rsp();
        rwm_pkg::t_rsp r;
        r = '0;
        r.hit_type = rwm_pkg::UNTYPED;
        return r;
    endfunction

    task automatic drop_rank(input int s);
        int r0;
        r0 = pr_rank[s];
        if (r0 == 0) return;
        for (int i = 0; i < 8; i++)
            if (pr_rank[i] > r0) pr_rank[i]--;
        pr_rank[s] = 0;
        pr_rank_cnt--;
    endtask

    function automatic bit span_has(input int s, input logic [32:0] a);
        logic [32:0] lo, hi;
        lo = {1'b0, pr_start[s][31:12], 12'h0};
        hi = ({1'b0, pr_end[s]} + 33'hfff) & ~33'hfff;
        return a >= lo && a <= hi;
    endfunction

    function automatic bit exact_has(input int s, input logic [31:0] a);
        return a >= pr_start[s] && a <= pr_end[s];
    endfunction

    task automatic monitor_predict(input rwm_pkg::t_req q, output rwm_pkg::t_rsp r);
        int found;
        logic [32:0] page;
        bit over, first, note;
        r = idle_rsp();
        found = -1;
        case (q.opcode)
            rwm_pkg::OP_LOAD: begin
                pr_start[q.slot] = q.start_addr;
                pr_end[q.slot] = q.end_addr;
                pr_kind[q.slot] = q.region_type;
                pr_mode[q.slot] = rwm_pkg::MODE_NONE;
                drop_rank(q.slot);
                for (int p = 0; p < 256; p++) pr_dirty[q.slot][p] = 1'b0;
                pr_total[q.slot] = 0;
                if (pr_last_ok && pr_last == q.slot) pr_last_ok = 1'b0;
            end
            rwm_pkg::OP_MODE: begin
                pr_mode[q.slot] = (q.mode == 2'd3) ? rwm_pkg::MODE_NONE : q.mode;
                if (pr_mode[q.slot] != rwm_pkg::MODE_NONE) begin
                    drop_rank(q.slot);
                    pr_rank_cnt++;
                    pr_rank[q.slot] = pr_rank_cnt;
                end
            end
            rwm_pkg::OP_WRITE: begin
                if (pr_last_ok && span_has(pr_last, {1'b0, q.address})) begin
                    r.address_valid = 1'b1;
                    if (exact_has(pr_last, q.address)) found = pr_last;
                end
                if (found < 0) begin
                    int best;
                    best = 0;
                    for (int i = 0; i < 8; i++) begin
                        if (pr_rank[i] == 0 || !span_has(i, {1'b0, q.address})) continue;
                        r.address_valid = 1'b1;
                        if (exact_has(i, q.address) && pr_rank[i] > best) begin
                            best = pr_rank[i];
                            found = i;
                        end
                    end
                    if (found >= 0) begin
                        pr_last = found;
                        pr_last_ok = 1'b1;
                    end
                end
                if (found >= 0) begin
                    page = ({1'b0, q.address} - {1'b0, pr_start[found][31:12], 12'h0}) >> 12;
                    over = page >= 256;
                    first = 1'b0;
                    note = 1'b0;
                    if (pr_kind[found] != rwm_pkg::UNTYPED &&
                        (pr_mode[found] == rwm_pkg::MODE_FIRST ||
                         pr_mode[found] == rwm_pkg::MODE_ALL)) begin
                        if (!over && !pr_dirty[found][page[7:0]]) begin
                            pr_dirty[found][page[7:0]] = 1'b1;
                            pr_total[found]++;
                            first = 1'b1;
                        end
                        note = (pr_mode[found] == rwm_pkg::MODE_ALL) || first;
                    end
                    r.region_hit = 1'b1;
                    r.hit_slot = found[2:0];
                    r.hit_type = pr_kind[found];
                    r.page_index = over ? 8'd255 : page[7:0];
                    r.first_write = first;
                    r.notify = note;
                    r.page_overflow = over;
                    r.dirty_count = pr_total[found][8:0];
                end
            end
            default: ;
        endcase
    endtask

    // sender: drives one transaction and waits for acceptance; called at a falling edge,
    // returns at the falling edge after acceptance with valid still high
    task automatic send_req(input rwm_pkg::t_req q);
        rwm_pkg::t_rsp r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= q;
        do @(posedge i_clk); while (!req_ch.ready);
        monitor_predict(q, r);
        rsp_queue.push_back(r);
        @(negedge i_clk);
    endtask

    function automatic rwm_pkg::t_req make_req(input logic [1:0] op, input logic [2:0] s,
                                               input logic [31:0] st, input logic [31:0] en,
                                               input logic [4:0] ty, input logic [1:0] m,
                                               input logic [31:0] a);
        rwm_pkg::t_req q;
        q.opcode = op; q.slot = s; q.start_addr = st; q.end_addr = en;
        q.region_type = ty; q.mode = m; q.address = a;
        return q;
    endfunction

    function automatic rwm_pkg::t_req rand_req();
        rwm_pkg::t_req q;
        int s;
        int pick;
        q.opcode = rwm_pkg::OP_WRITE;
        q.slot = 3'($urandom_range(7));
        q.start_addr = $urandom;
        q.end_addr = $urandom;
        q.region_type = ($urandom_range(5) == 0) ? rwm_pkg::UNTYPED
                                                 : 5'($urandom_range(31));
        q.mode = 2'($urandom_range(3));
        q.address = $urandom;
        pick = $urandom_range(99);
        if (pick < 6) begin
            q.opcode = rwm_pkg::OP_LOAD;
            // mostly small regions somewhere in a compact window, so writes hit
            if ($urandom_range(3) != 0) begin
                q.start_addr = {12'h0, 20'($urandom_range(20'h3ffff))};
                q.end_addr = q.start_addr + $urandom_range(32'h120000);
            end
        end else if (pick < 12) begin
            q.opcode = rwm_pkg::OP_MODE;
        end else if (pick < 14) begin
            q.opcode = 2'd3;
        end else if (pick < 90) begin
            s = $urandom_range(7);
            q.address = pr_start[s] + $urandom_range(32'h140000) - 32'h1000;
        end
        return q;
    endfunction

    // receiver: checks each response in order
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_queue.size() == 0) begin
                report_mismatch("unexpected response", 32'(rsp_ch.data), 0);
            end else begin
                rwm_pkg::t_rsp e, g;
                e = rsp_queue.pop_front();
                g = rsp_ch.data;
                if (g.address_valid !== e.address_valid)
                    report_mismatch("address_valid", g.address_valid, e.address_valid);
                if (g.region_hit !== e.region_hit)
                    report_mismatch("region_hit", g.region_hit, e.region_hit);
                if (g.hit_slot !== e.hit_slot)
                    report_mismatch("hit_slot", g.hit_slot, e.hit_slot);
                if (g.hit_type !== e.hit_type)
                    report_mismatch("hit_type", g.hit_type, e.hit_type);
                if (g.page_index !== e.page_index)
                    report_mismatch("page_index", g.page_index, e.page_index);
                if (g.first_write !== e.first_write)
                    report_mismatch("first_write", g.first_write, e.first_write);
                if (g.notify !== e.notify)
                    report_mismatch("notify", g.notify, e.notify);
                if (g.page_overflow !== e.page_overflow)
                    report_mismatch("page_overflow", g.page_overflow, e.page_overflow);
                if (g.dirty_count !== e.dirty_count)
                    report_mismatch("dirty_count", g.dirty_count, e.dirty_count);
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= !recv_hold &&
                        !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    initial begin
        #20000000;
        $display("FAIL region_write_monitor");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_row row;
        rwm_pkg::t_rsp got_exp;
        rwm_pkg::t_rsp hit;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        for (int i = 0; i < 8; i++) begin
            pr_start[i] = '0; pr_end[i] = '0; pr_kind[i] = rwm_pkg::UNTYPED;
            pr_mode[i] = rwm_pkg::MODE_NONE; pr_rank[i] = 0; pr_total[i] = 0;
            for (int p = 0; p < 256; p++) pr_dirty[i][p] = 1'b0;
        end
        pr_rank_cnt = 0;
        pr_last = 0;
        pr_last_ok = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        hit = idle_rsp();
        hit.address_valid = 1'b1; hit.region_hit = 1'b1; hit.hit_type = 5'd3;
        hit.first_write = 1'b1; hit.notify = 1'b1; hit.dirty_count = 9'd1;
        // directed table; rows with has_exp set carry a fixed expectation
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h0), 1, idle_rsp()});
        rows.push_back('{make_req(2'd3, 7, '1, '1, '1, 2'd3, '1), 1, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_LOAD, 0, 32'h0, 32'h0ff_fff, 5'd3, 0, 0),
                         1, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h10), 1, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_MODE, 0, 0, 0, 0, rwm_pkg::MODE_FIRST, 0),
                         1, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h0), 1, hit});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h4), 0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'hff_fff),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h100_000),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_LOAD, 1, 32'h200_800, 32'h400_123, 5'd7, 0, 0),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_MODE, 1, 0, 0, 0, rwm_pkg::MODE_ALL, 0),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h3ff_000),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h300_000),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h3ff_000),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h200_000),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_LOAD, 7, '1 - 32'h1000, '1, rwm_pkg::UNTYPED,
                                  0, 0), 0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_MODE, 7, 0, 0, 0, 2'd3, 0), 0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_MODE, 7, 0, 0, 0, rwm_pkg::MODE_ALL, 0),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, '1), 0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_LOAD, 2, 32'h5000, 32'h4000, 5'd0, 0, 0),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_MODE, 2, 0, 0, 0, rwm_pkg::MODE_FIRST, 0),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h4800),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_MODE, 1, 0, 0, 0, rwm_pkg::MODE_NONE, 0),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 32'h300_000),
                         0, idle_rsp()});
        rows.push_back('{make_req(rwm_pkg::OP_LOAD, 1, 32'h200_800, 32'h400_123, 5'd7, 0, 0),
                         0, idle_rsp()});
        foreach (rows[i]) begin
            row = rows[i];
            send_req(row.req);
            if (row.has_exp) begin
                got_exp = rsp_queue[$];
                if (got_exp !== row.exp)
                    report_mismatch("directed row", i, 32'(got_exp));
                rsp_queue[$] = row.exp;
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 32 : 0;
            for (int n = 0; n < 530; n++) begin
                if (phase == 2 && n == 100) begin
                    // long receiver hold-off while requests keep coming
                    fork
                        begin
                            recv_hold = 1'b1;
                            repeat (300) @(posedge i_clk);
                            recv_hold = 1'b0;
                        end
                    join_none
                end
                if (n == 400) begin
                    req_ch.valid <= 1'b0;
                    wait (rsp_queue.size() == 0);
                    @(negedge i_clk);
                end
                send_req(rand_req());
            end
        end

        req_ch.valid <= 1'b0;
        wait (rsp_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS region_write_monitor");
        else
            $display("FAIL region_write_monitor");
        $finish;
    end
endmodule
